### rtl/hvsp_pkg.sv
// Shared types, operation codes and frame tables for the HVSP command sequencer.
package hvsp_pkg;

    // Depth of the job queue between front and back end
    localparam int unsigned JOB_QUEUE_DEPTH = 2;

    // Operation codes
    localparam logic [4:0] OP_SET_ADDRESS   = 5'd0;
    localparam logic [4:0] OP_CHIP_ERASE    = 5'd1;
    localparam logic [4:0] OP_FLASH_WR_ENT  = 5'd2;
    localparam logic [4:0] OP_EEP_WR_ENT    = 5'd3;
    localparam logic [4:0] OP_FLASH_LOAD    = 5'd4;
    localparam logic [4:0] OP_EEP_LOAD      = 5'd5;
    localparam logic [4:0] OP_FLASH_COMMIT  = 5'd6;
    localparam logic [4:0] OP_EEP_COMMIT    = 5'd7;
    localparam logic [4:0] OP_FLASH_WR_WORD = 5'd8;
    localparam logic [4:0] OP_EEP_WR_BYTE   = 5'd9;
    localparam logic [4:0] OP_FLASH_RD_ENT  = 5'd10;
    localparam logic [4:0] OP_EEP_RD_ENT    = 5'd11;
    localparam logic [4:0] OP_FLASH_RD_WORD = 5'd12;
    localparam logic [4:0] OP_EEP_RD_BYTE   = 5'd13;
    localparam logic [4:0] OP_LEAVE         = 5'd14;
    localparam logic [4:0] OP_FUSE_WRITE    = 5'd15;
    localparam logic [4:0] OP_LOCK_WRITE    = 5'd16;
    localparam logic [4:0] OP_FUSE_READ     = 5'd17;
    localparam logic [4:0] OP_LOCK_READ     = 5'd18;
    localparam logic [4:0] OP_SIG_READ      = 5'd19;
    localparam logic [4:0] OP_CAL_READ      = 5'd20;

    // Fuse select value that names no fuse
    localparam logic [1:0] FUSE_NONE = 2'd3;

    // Capture codes
    localparam logic [1:0] CAP_NONE = 2'd0;
    localparam logic [1:0] CAP_LOW  = 2'd1;
    localparam logic [1:0] CAP_HIGH = 2'd2;

    // Common instruction bytes
    localparam logic [7:0] INS_LOAD_CMD  = 8'h4C;
    localparam logic [7:0] INS_ADDR_LO   = 8'h0C;
    localparam logic [7:0] INS_ADDR_HI   = 8'h1C;
    localparam logic [7:0] INS_DATA_LO   = 8'h2C;
    localparam logic [7:0] INS_DATA_HI   = 8'h3C;
    localparam logic [7:0] INS_WR_LO_A   = 8'h64;
    localparam logic [7:0] INS_WR_LO_B   = 8'h6C;
    localparam logic [7:0] INS_RD_LO_A   = 8'h68;
    localparam logic [7:0] INS_RD_HI_A   = 8'h78;
    localparam logic [7:0] INS_HI_B      = 8'h7C;

    // Command bytes sent with the load-command instruction
    localparam logic [7:0] CMD_CHIP_ERASE = 8'h80;
    localparam logic [7:0] CMD_FLASH_WR   = 8'h10;
    localparam logic [7:0] CMD_EEP_WR     = 8'h11;
    localparam logic [7:0] CMD_FLASH_RD   = 8'h02;
    localparam logic [7:0] CMD_EEP_RD     = 8'h03;
    localparam logic [7:0] CMD_NOP        = 8'h00;
    localparam logic [7:0] CMD_FUSE_WR    = 8'h40;
    localparam logic [7:0] CMD_LOCK_WR    = 8'h20;
    localparam logic [7:0] CMD_FUSE_RD    = 8'h04;
    localparam logic [7:0] CMD_SIG_RD     = 8'h08;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] address;
        logic [7:0]  data_low;
        logic [7:0]  data_high;
        logic [1:0]  fuse_select;
        logic [7:0]  signature_index;
        logic        word_mode;
    } in_t;

    typedef struct packed {
        logic [7:0] instruction;
        logic [7:0] data_byte;
        logic       wait_ready;
        logic [1:0] capture;
        logic       last_frame;
    } out_t;

    // One classified operation with the state it sampled at acceptance
    typedef struct packed {
        logic [4:0] op;
        logic [7:0] addr_lo;
        logic [7:0] addr_hi;
        logic [7:0] page_hi;
        logic [7:0] data_low;
        logic [7:0] data_high;
        logic [1:0] fuse_select;
        logic [7:0] signature_index;
        logic       word_mode;
        logic       send_hi;
    } job_t;

    function automatic logic [7:0] fuse_write_a(input logic [1:0] sel);
        logic [7:0] v;
        case (sel)
            2'd0:    v = 8'h64;
            2'd1:    v = 8'h74;
            2'd2:    v = 8'h66;
            default: v = 8'h64;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] fuse_write_b(input logic [1:0] sel);
        logic [7:0] v;
        case (sel)
            2'd0:    v = 8'h6C;
            2'd1:    v = 8'h7C;
            2'd2:    v = 8'h6E;
            default: v = 8'h6C;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] fuse_read_a(input logic [1:0] sel);
        logic [7:0] v;
        case (sel)
            2'd0:    v = 8'h68;
            2'd1:    v = 8'h7A;
            2'd2:    v = 8'h6A;
            default: v = 8'h68;
        endcase
        return v;
    endfunction

    // Number of frames in a job's run
    function automatic logic [2:0] job_len(input job_t j);
        logic [2:0] n;
        case (j.op)
            OP_CHIP_ERASE:    n = 3'd3;
            OP_FLASH_WR_ENT:  n = j.word_mode ? 3'd2 : 3'd1;
            OP_EEP_WR_ENT:    n = 3'd1;
            OP_FLASH_LOAD:    n = 3'd7;
            OP_EEP_LOAD:      n = 3'd5;
            OP_FLASH_COMMIT:  n = 3'd3;
            OP_EEP_COMMIT:    n = 3'd2;
            OP_FLASH_WR_WORD: n = 3'd7;
            OP_EEP_WR_BYTE:   n = 3'd4;
            OP_FLASH_RD_ENT:  n = 3'd1;
            OP_EEP_RD_ENT:    n = 3'd1;
            OP_FLASH_RD_WORD: n = j.send_hi ? 3'd6 : 3'd5;
            OP_EEP_RD_BYTE:   n = 3'd4;
            OP_LEAVE:         n = 3'd1;
            OP_FUSE_WRITE:    n = 3'd4;
            OP_LOCK_WRITE:    n = 3'd4;
            OP_FUSE_READ:     n = 3'd3;
            OP_LOCK_READ:     n = 3'd3;
            OP_SIG_READ:      n = 3'd4;
            OP_CAL_READ:      n = 3'd4;
            default:          n = 3'd1;
        endcase
        return n;
    endfunction

    // Frame number idx of a job's run
    function automatic out_t frame_at(input job_t j, input logic [2:0] idx);
        out_t       f;
        logic [2:0] k;
        f = '0;
        k = idx;
        // a flash word read on the same page drops its high-address frame
        if (j.op == OP_FLASH_RD_WORD && !j.send_hi && idx != 3'd0) begin
            k = idx + 3'd1;
        end
        case (j.op)
            OP_CHIP_ERASE: begin
                case (k)
                    3'd0:    f.instruction = INS_LOAD_CMD;
                    3'd1:    f.instruction = INS_WR_LO_A;
                    default: f.instruction = INS_WR_LO_B;
                endcase
                if (k == 3'd0) f.data_byte = CMD_CHIP_ERASE;
                f.wait_ready = (k == 3'd2);
            end
            OP_FLASH_WR_ENT: begin
                if (k == 3'd0) begin
                    f.instruction = INS_LOAD_CMD;
                    f.data_byte   = CMD_FLASH_WR;
                end else begin
                    f.instruction = INS_ADDR_HI;
                    f.data_byte   = j.addr_hi;
                end
            end
            OP_EEP_WR_ENT: begin
                f.instruction = INS_LOAD_CMD;
                f.data_byte   = CMD_EEP_WR;
            end
            OP_FLASH_LOAD, OP_FLASH_WR_WORD: begin
                case (k)
                    3'd0: begin
                        f.instruction = INS_ADDR_LO;
                        f.data_byte   = j.addr_lo;
                    end
                    3'd1: begin
                        f.instruction = INS_DATA_LO;
                        f.data_byte   = j.data_low;
                    end
                    3'd2: f.instruction = (j.op == OP_FLASH_LOAD) ? 8'h6D : INS_WR_LO_A;
                    3'd3: f.instruction = INS_WR_LO_B;
                    3'd4: begin
                        f.instruction = INS_DATA_HI;
                        f.data_byte   = j.data_high;
                    end
                    3'd5: f.instruction = (j.op == OP_FLASH_LOAD) ? 8'h7D : 8'h74;
                    default: begin
                        f.instruction = INS_HI_B;
                        f.wait_ready  = (j.op == OP_FLASH_WR_WORD);
                    end
                endcase
            end
            OP_EEP_LOAD: begin
                case (k)
                    3'd0: begin
                        f.instruction = INS_ADDR_LO;
                        f.data_byte   = j.addr_lo;
                    end
                    3'd1: begin
                        f.instruction = INS_ADDR_HI;
                        f.data_byte   = j.addr_hi;
                    end
                    3'd2: begin
                        f.instruction = INS_DATA_LO;
                        f.data_byte   = j.data_low;
                    end
                    3'd3:    f.instruction = 8'h6D;
                    default: f.instruction = INS_WR_LO_B;
                endcase
            end
            OP_FLASH_COMMIT: begin
                case (k)
                    3'd0: begin
                        f.instruction = INS_ADDR_HI;
                        f.data_byte   = j.page_hi;
                    end
                    3'd1:    f.instruction = INS_WR_LO_A;
                    default: begin
                        f.instruction = INS_WR_LO_B;
                        f.wait_ready  = 1'b1;
                    end
                endcase
            end
            OP_EEP_COMMIT: begin
                f.instruction = (k == 3'd0) ? INS_WR_LO_A : INS_WR_LO_B;
                f.wait_ready  = (k != 3'd0);
            end
            OP_EEP_WR_BYTE: begin
                case (k)
                    3'd0: begin
                        f.instruction = INS_ADDR_LO;
                        f.data_byte   = j.addr_lo;
                    end
                    3'd1: begin
                        f.instruction = INS_DATA_LO;
                        f.data_byte   = j.data_low;
                    end
                    3'd2:    f.instruction = INS_WR_LO_A;
                    default: begin
                        f.instruction = INS_WR_LO_B;
                        f.wait_ready  = 1'b1;
                    end
                endcase
            end
            OP_FLASH_RD_ENT: begin
                f.instruction = INS_LOAD_CMD;
                f.data_byte   = CMD_FLASH_RD;
            end
            OP_EEP_RD_ENT: begin
                f.instruction = INS_LOAD_CMD;
                f.data_byte   = CMD_EEP_RD;
            end
            OP_FLASH_RD_WORD, OP_EEP_RD_BYTE: begin
                case (k)
                    3'd0: begin
                        f.instruction = INS_ADDR_LO;
                        f.data_byte   = j.addr_lo;
                    end
                    3'd1: begin
                        f.instruction = INS_ADDR_HI;
                        f.data_byte   = j.addr_hi;
                    end
                    3'd2: f.instruction = INS_RD_LO_A;
                    3'd3: begin
                        f.instruction = INS_WR_LO_B;
                        f.capture     = CAP_LOW;
                    end
                    3'd4:    f.instruction = INS_RD_HI_A;
                    default: begin
                        f.instruction = INS_HI_B;
                        f.capture     = CAP_HIGH;
                    end
                endcase
            end
            OP_LEAVE: begin
                f.instruction = INS_LOAD_CMD;
                f.data_byte   = CMD_NOP;
            end
            OP_FUSE_WRITE, OP_LOCK_WRITE: begin
                case (k)
                    3'd0: begin
                        f.instruction = INS_LOAD_CMD;
                        f.data_byte   = (j.op == OP_FUSE_WRITE) ? CMD_FUSE_WR : CMD_LOCK_WR;
                    end
                    3'd1: begin
                        f.instruction = INS_DATA_LO;
                        f.data_byte   = j.data_low;
                    end
                    3'd2: begin
                        f.instruction = (j.op == OP_FUSE_WRITE) ?
                                        fuse_write_a(j.fuse_select) : INS_WR_LO_A;
                    end
                    default: begin
                        f.instruction = (j.op == OP_FUSE_WRITE) ?
                                        fuse_write_b(j.fuse_select) : INS_WR_LO_B;
                        f.wait_ready  = 1'b1;
                    end
                endcase
            end
            OP_FUSE_READ, OP_LOCK_READ: begin
                case (k)
                    3'd0: begin
                        f.instruction = INS_LOAD_CMD;
                        f.data_byte   = CMD_FUSE_RD;
                    end
                    3'd1: begin
                        f.instruction = (j.op == OP_FUSE_READ) ?
                                        fuse_read_a(j.fuse_select) : INS_RD_HI_A;
                    end
                    default: begin
                        f.instruction = (j.op == OP_FUSE_READ) ?
                                        fuse_write_b(j.fuse_select) : INS_WR_LO_B;
                        f.capture     = CAP_LOW;
                    end
                endcase
            end
            OP_SIG_READ, OP_CAL_READ: begin
                case (k)
                    3'd0: begin
                        f.instruction = INS_LOAD_CMD;
                        f.data_byte   = CMD_SIG_RD;
                    end
                    3'd1: begin
                        f.instruction = INS_ADDR_LO;
                        f.data_byte   = (j.op == OP_SIG_READ) ? j.signature_index : 8'h00;
                    end
                    3'd2: f.instruction = (j.op == OP_SIG_READ) ? INS_RD_LO_A : INS_RD_HI_A;
                    default: begin
                        f.instruction = (j.op == OP_SIG_READ) ? INS_WR_LO_B : INS_HI_B;
                        f.capture     = CAP_LOW;
                    end
                endcase
            end
            default: f = '0;
        endcase
        f.last_frame = (idx == job_len(j) - 3'd1);
        return f;
    endfunction

endpackage

### rtl/hvsp_front.sv
// Front end: accepts operations, tracks address state and classifies them into jobs.
module hvsp_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  hvsp_pkg::in_t      s_data,
    input  logic               queue_full,
    output logic               push,
    output hvsp_pkg::job_t     push_job
);
    import hvsp_pkg::*;

    logic [15:0] word_address_reg;
    logic [15:0] page_start_reg;
    logic [7:0]  last_read_page_reg;
    logic        s_fire;
    logic        has_frames;
    logic        send_hi;

    assign s_ready = !queue_full;
    assign s_fire  = s_valid && s_ready;

    // classify: does this operation produce any frame
    always_comb begin
        has_frames = 1'b0;
        if (s_data.kind inside {[OP_CHIP_ERASE:OP_CAL_READ]}) begin
            has_frames = 1'b1;
        end
        if ((s_data.kind == OP_FUSE_WRITE || s_data.kind == OP_FUSE_READ) &&
            s_data.fuse_select == FUSE_NONE) begin
            has_frames = 1'b0;
        end
    end

    assign send_hi = (word_address_reg[15:8] != last_read_page_reg);

    // build the job from the operation and the sampled state
    always_comb begin
        push_job.op              = s_data.kind;
        push_job.addr_lo         = word_address_reg[7:0];
        push_job.addr_hi         = word_address_reg[15:8];
        push_job.page_hi         = page_start_reg[15:8];
        push_job.data_low        = s_data.data_low;
        push_job.data_high       = s_data.data_high;
        push_job.fuse_select     = s_data.fuse_select;
        push_job.signature_index = s_data.signature_index;
        push_job.word_mode       = s_data.word_mode;
        push_job.send_hi         = send_hi;
    end

    assign push = s_fire && has_frames;

    // advance address state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_address_reg   <= '0;
            page_start_reg     <= '0;
            last_read_page_reg <= 8'hFF;
        end else if (s_fire) begin
            case (s_data.kind)
                OP_SET_ADDRESS: begin
                    word_address_reg <= s_data.address;
                    page_start_reg   <= s_data.address;
                end
                OP_FLASH_WR_ENT: page_start_reg <= word_address_reg;
                OP_FLASH_RD_ENT: last_read_page_reg <= 8'hFF;
                OP_FLASH_RD_WORD: begin
                    word_address_reg   <= word_address_reg + 16'd1;
                    last_read_page_reg <= word_address_reg[15:8];
                end
                OP_FLASH_LOAD, OP_EEP_LOAD, OP_FLASH_WR_WORD, OP_EEP_WR_BYTE,
                OP_EEP_RD_BYTE: begin
                    word_address_reg <= word_address_reg + 16'd1;
                end
                default: ;
            endcase
        end
    end

    // set address loads the running address
    a_set_address: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.kind == OP_SET_ADDRESS) |=>
            (word_address_reg == $past(s_data.address)))
        else $error("set address did not load the word address");

endmodule

### rtl/hvsp_job_fifo.sv
// Job queue between the front end and the frame sequencer.
module hvsp_job_fifo #(
    parameter int unsigned DEPTH = hvsp_pkg::JOB_QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  hvsp_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output hvsp_pkg::job_t head_job
);
    import hvsp_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];

    // hold job payloads
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    // advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("job popped from an empty queue");

endmodule

### rtl/hvsp_back.sv
// Back end: walks each queued job frame by frame into the output register.
module hvsp_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           head_valid,
    input  hvsp_pkg::job_t head_job,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output hvsp_pkg::out_t m_data
);
    import hvsp_pkg::*;

    logic [2:0] idx_reg;
    logic       m_valid_reg;
    out_t       m_data_reg;
    out_t       frame;
    logic       fire;

    assign frame = frame_at(head_job, idx_reg);
    assign fire  = head_valid && (!m_valid_reg || m_ready);
    assign pop   = fire && frame.last_frame;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // load the output register whenever it is free or being drained
    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= frame;
        end
    end

    // step through the run; drop valid once the transaction is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                m_valid_reg <= 1'b1;
                idx_reg     <= frame.last_frame ? 3'd0 : idx_reg + 3'd1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    a_idx_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> (idx_reg < job_len(head_job)))
        else $error("frame index ran past the end of the job");

    a_capture_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.capture != 2'd3))
        else $error("undefined capture code on output");

endmodule

### rtl/hvsp_command_sequencer_unit.sv
// Top level of the HVSP command sequencer: front end, job queue and frame sequencer.
// Each accepted operation yields its run of one to seven high-voltage serial frames,
// one frame per clock cycle into the output register while m_ready does not stall it
// (seven frames for a flash paged load or word write). The front end takes one
// operation per cycle while the job queue (QUEUE_DEPTH entries) has room; set
// address, an unknown code and a fuse operation with fuse select three are
// accepted and emit nothing. The running word address, page start and last read
// page are updated as operations enter, so no frame depends on a later operation.
// There is no clearing pass after reset.
module hvsp_command_sequencer_unit #(
    parameter int unsigned QUEUE_DEPTH = hvsp_pkg::JOB_QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  hvsp_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output hvsp_pkg::out_t m_data
);
    import hvsp_pkg::*;

    logic push;
    logic pop;
    logic queue_full;
    logic head_valid;
    job_t push_job;
    job_t head_job;

    hvsp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    hvsp_job_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    hvsp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
